@@ sv/csf_pkg.sv @@
// Shared types and constants for the capacity-limited split FIFO.
package csf_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int QTY_WIDTH_DEF = 32;
  localparam int ID_WIDTH_DEF  = 16;

  localparam int STATUS_W = 3;
  localparam int FUNC_W   = 2;

  // Configuration register indexes
  localparam logic CFG_CAPACITY  = 1'b0;
  localparam logic CFG_UNLIMITED = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH    = 2'd0,
    FN_POP_QTY = 2'd1,
    FN_POP_CNT = 2'd2,
    FN_POP_ONE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_OVERCAP = 3'd1,
    ST_DUP     = 3'd2,
    ST_SHORT   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_CAP,
    S_RD,
    S_EV,
    S_PUSHW,
    S_FREE,
    S_SOLO,
    S_ERD,
    S_EEV
  } state_t;

endpackage

@@ sv/capacity_limited_split_fifo_top.sv @@
// FIFO of tagged quantities with a capacity limit, split pops and per-transfer status.
// One request is taken at a time; s_axis_tready is high only between requests. Every entry
// visit goes through the single memory read port in an address state and an evaluate state.
// A push runs the duplicate search over the stored entries, cut short at a match, after
// the capacity check, which unlimited mode skips; a push may also be refused by that check
// or for overflowing the word. A pop that removes R entries or parts makes a first pass
// over the same R entries to fix the final count and total, then sends R results, one
// per entry read; refusals and empty pops send a single result. A stalled master side
// holds the emit pass. Every result of a request reports the count, total and free
// space as they stand after the whole request.
module capacity_limited_split_fifo_top import csf_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int QTY_WIDTH = QTY_WIDTH_DEF,
  parameter int ID_WIDTH  = ID_WIDTH_DEF,
  localparam int CW       = $clog2(DEPTH + 1),
  localparam int AW       = $clog2(DEPTH),
  localparam int IN_BITS  = FUNC_W + ID_WIDTH + QTY_WIDTH + CW,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = STATUS_W + ID_WIDTH + QTY_WIDTH + CW + QTY_WIDTH + QTY_WIDTH + 1,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // func, item_id, quantity, pop_count
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status, out_id, out_qty, entry_count, total_qty, free_space
  output logic [OUT_W-1:0]     m_axis_tdata,
  // item_valid
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [QTY_WIDTH-1:0] cfg_wdata
);

  logic [FUNC_W-1:0]    in_func;
  logic [ID_WIDTH-1:0]  in_id;
  logic [QTY_WIDTH-1:0] in_qty;
  logic [CW-1:0]        in_cnt;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [ID_WIDTH-1:0]  mem_wid, mem_rid;
  logic [QTY_WIDTH-1:0] mem_wamt, mem_ramt;

  logic [QTY_WIDTH-1:0] alu_a, alu_b;
  logic                 alu_sub;
  logic [QTY_WIDTH:0]   alu_res;

  logic [STATUS_W-1:0]  out_status;
  logic [ID_WIDTH-1:0]  out_id;
  logic [QTY_WIDTH-1:0] out_qty, out_total;
  logic [CW-1:0]        out_count;
  logic [QTY_WIDTH:0]   out_free;

  assign in_func = s_axis_tdata[FUNC_W-1:0];
  assign in_id   = s_axis_tdata[FUNC_W +: ID_WIDTH];
  assign in_qty  = s_axis_tdata[FUNC_W + ID_WIDTH +: QTY_WIDTH];
  assign in_cnt  = s_axis_tdata[FUNC_W + ID_WIDTH + QTY_WIDTH +: CW];

  assign m_axis_tdata = OUT_W'({out_free, out_total, out_count, out_qty, out_id, out_status});

  csf_store #(
    .DEPTH     (DEPTH),
    .QTY_WIDTH (QTY_WIDTH),
    .ID_WIDTH  (ID_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wid   (mem_wid),
    .wamt  (mem_wamt),
    .raddr (mem_raddr),
    .rid   (mem_rid),
    .ramt  (mem_ramt)
  );

  csf_alu #(
    .QTY_WIDTH (QTY_WIDTH)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  csf_seq #(
    .DEPTH     (DEPTH),
    .QTY_WIDTH (QTY_WIDTH),
    .ID_WIDTH  (ID_WIDTH)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_func        (in_func),
    .in_id          (in_id),
    .in_qty         (in_qty),
    .in_cnt         (in_cnt),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wid        (mem_wid),
    .mem_wamt       (mem_wamt),
    .mem_raddr      (mem_raddr),
    .mem_rid        (mem_rid),
    .mem_ramt       (mem_ramt),
    .alu_a          (alu_a),
    .alu_b          (alu_b),
    .alu_sub        (alu_sub),
    .alu_res        (alu_res),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_status     (out_status),
    .out_item_valid (m_axis_tuser),
    .out_id         (out_id),
    .out_qty        (out_qty),
    .out_last       (m_axis_tlast),
    .out_count      (out_count),
    .out_total      (out_total),
    .out_free       (out_free)
  );

endmodule

@@ sv/csf_alu.sv @@
// Shared add/subtract unit with carry or borrow in the top bit.
module csf_alu import csf_pkg::*; #(
  parameter int QTY_WIDTH = QTY_WIDTH_DEF
) (
  input  logic [QTY_WIDTH-1:0] a,
  input  logic [QTY_WIDTH-1:0] b,
  input  logic                 sub,
  output logic [QTY_WIDTH:0]   res
);

  // Top bit is carry on add, borrow on subtract; as a signed value it is a - b.
  always_comb begin
    if (sub) begin
      res = {1'b0, a} - {1'b0, b};
    end else begin
      res = {1'b0, a} + {1'b0, b};
    end
  end

endmodule

@@ sv/csf_store.sv @@
// Entry memory: identifier and quantity per slot, one write and one registered read port.
module csf_store import csf_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int QTY_WIDTH = QTY_WIDTH_DEF,
  parameter int ID_WIDTH  = ID_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [ID_WIDTH-1:0]  wid,
  input  logic [QTY_WIDTH-1:0] wamt,
  input  logic [AW-1:0]        raddr,
  output logic [ID_WIDTH-1:0]  rid,
  output logic [QTY_WIDTH-1:0] ramt
);

  logic [ID_WIDTH-1:0]  id_mem  [DEPTH];
  logic [QTY_WIDTH-1:0] amt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      id_mem[waddr]  <= wid;
      amt_mem[waddr] <= wamt;
    end
  end

  always_ff @(posedge clk) begin
    rid  <= id_mem[raddr];
    ramt <= amt_mem[raddr];
  end

endmodule

@@ sv/csf_seq.sv @@
// Sequencer: request checks, scan and emit passes, queue state and result register.
module csf_seq import csf_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int QTY_WIDTH = QTY_WIDTH_DEF,
  parameter int ID_WIDTH  = ID_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  // request
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [ID_WIDTH-1:0]  in_id,
  input  logic [QTY_WIDTH-1:0] in_qty,
  input  logic [CW-1:0]        in_cnt,
  // configuration
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [QTY_WIDTH-1:0] cfg_wdata,
  // entry memory
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [ID_WIDTH-1:0]  mem_wid,
  output logic [QTY_WIDTH-1:0] mem_wamt,
  output logic [AW-1:0]        mem_raddr,
  input  logic [ID_WIDTH-1:0]  mem_rid,
  input  logic [QTY_WIDTH-1:0] mem_ramt,
  // shared add/subtract unit
  output logic [QTY_WIDTH-1:0] alu_a,
  output logic [QTY_WIDTH-1:0] alu_b,
  output logic                 alu_sub,
  input  logic [QTY_WIDTH:0]   alu_res,
  // result
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_item_valid,
  output logic [ID_WIDTH-1:0]  out_id,
  output logic [QTY_WIDTH-1:0] out_qty,
  output logic                 out_last,
  output logic [CW-1:0]        out_count,
  output logic [QTY_WIDTH-1:0] out_total,
  output logic [QTY_WIDTH:0]   out_free
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT   = CW'(1);

  state_t state, state_next;

  // queue state
  logic [AW-1:0]        head, head_next, tail, tail_next;
  logic [CW-1:0]        fill, fill_next;
  logic [QTY_WIDTH-1:0] total, total_next;
  logic [QTY_WIDTH-1:0] capacity;
  logic                 unlimited;

  // request and working registers
  func_t                req_func, req_func_next;
  logic [ID_WIDTH-1:0]  req_id, req_id_next;
  logic [QTY_WIDTH-1:0] req_qty, req_qty_next;
  logic [CW-1:0]        req_cnt, req_cnt_next;
  logic [QTY_WIDTH-1:0] sum, sum_next;
  logic [AW-1:0]        scan_ptr, scan_ptr_next;
  logic [CW-1:0]        k, k_next;
  logic [QTY_WIDTH-1:0] left, left_next;
  logic                 part, part_next;
  logic [QTY_WIDTH-1:0] part_qty, part_qty_next;
  logic [CW-1:0]        nres, nres_next;
  logic [CW-1:0]        fill_f, fill_f_next;
  logic [QTY_WIDTH-1:0] total_f, total_f_next;
  logic [QTY_WIDTH:0]   free_r, free_r_next;
  status_t              st, st_next;
  logic                 single, single_next;

  // result register load
  logic                 out_load, out_free_slot;
  status_t              ld_status;
  logic                 ld_item_valid, ld_last;
  logic [ID_WIDTH-1:0]  ld_id;
  logic [QTY_WIDTH-1:0] ld_qty;

  logic [CW-1:0]        k_inc;
  logic                 is_last;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  assign in_ready      = (state == S_IDLE);
  assign out_free_slot = !out_valid || out_ready;
  assign k_inc         = k + ONE_CNT;
  assign is_last       = (k_inc == nres);
  assign mem_raddr     = (state == S_ERD || state == S_EEV) ? head : scan_ptr;

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    fill_next     = fill;
    total_next    = total;
    req_func_next = req_func;
    req_id_next   = req_id;
    req_qty_next  = req_qty;
    req_cnt_next  = req_cnt;
    sum_next      = sum;
    scan_ptr_next = scan_ptr;
    k_next        = k;
    left_next     = left;
    part_next     = part;
    part_qty_next = part_qty;
    nres_next     = nres;
    fill_f_next   = fill_f;
    total_f_next  = total_f;
    free_r_next   = free_r;
    st_next       = st;
    single_next   = single;

    alu_a   = total;
    alu_b   = req_qty;
    alu_sub = 1'b0;

    mem_we    = 1'b0;
    mem_waddr = tail;
    mem_wid   = req_id;
    mem_wamt  = req_qty;

    out_load      = 1'b0;
    ld_status     = ST_OK;
    ld_item_valid = 1'b0;
    ld_id         = '0;
    ld_qty        = '0;
    ld_last       = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_func_next = func_t'(in_func);
          req_id_next   = in_id;
          req_qty_next  = in_qty;
          req_cnt_next  = (func_t'(in_func) == FN_POP_ONE) ? ONE_CNT : in_cnt;
          state_next    = S_CHK;
        end
      end

      S_CHK: begin
        k_next        = '0;
        scan_ptr_next = head;
        fill_f_next   = fill;
        total_f_next  = total;
        single_next   = 1'b1;
        unique case (req_func)
          FN_PUSH: begin
            sum_next = alu_res[QTY_WIDTH-1:0];
            if (alu_res[QTY_WIDTH]) begin
              st_next    = ST_OVERCAP;
              state_next = S_FREE;
            end else if (!unlimited) begin
              state_next = S_CAP;
            end else if (fill == '0) begin
              state_next = S_PUSHW;
            end else begin
              state_next = S_RD;
            end
          end
          FN_POP_QTY: begin
            alu_sub = 1'b1;
            if (alu_res[QTY_WIDTH]) begin
              st_next    = ST_SHORT;
              state_next = S_FREE;
            end else if (req_qty == '0) begin
              st_next    = ST_OK;
              state_next = S_FREE;
            end else begin
              total_f_next = alu_res[QTY_WIDTH-1:0];
              left_next    = req_qty;
              single_next  = 1'b0;
              state_next   = S_RD;
            end
          end
          default: begin
            if (req_cnt > fill) begin
              st_next    = ST_SHORT;
              state_next = S_FREE;
            end else if (req_cnt == '0) begin
              st_next    = ST_OK;
              state_next = S_FREE;
            end else begin
              single_next = 1'b0;
              state_next  = S_RD;
            end
          end
        endcase
      end

      S_CAP: begin
        alu_a   = capacity;
        alu_b   = sum;
        alu_sub = 1'b1;
        if (alu_res[QTY_WIDTH]) begin
          st_next    = ST_OVERCAP;
          state_next = S_FREE;
        end else if (fill == '0) begin
          state_next = S_PUSHW;
        end else begin
          state_next = S_RD;
        end
      end

      S_RD: begin
        state_next = S_EV;
      end

      // First pass: duplicate search, or find where the pop ends
      S_EV: begin
        unique case (req_func)
          FN_PUSH: begin
            if (mem_rid == req_id) begin
              st_next    = ST_DUP;
              state_next = S_FREE;
            end else if (k_inc == fill) begin
              state_next = S_PUSHW;
            end else begin
              k_next        = k_inc;
              scan_ptr_next = next_slot(scan_ptr);
              state_next    = S_RD;
            end
          end
          FN_POP_QTY: begin
            alu_a   = left;
            alu_b   = mem_ramt;
            alu_sub = 1'b1;
            if (alu_res[QTY_WIDTH]) begin
              // front entry larger than what is still needed: split it
              part_next     = 1'b1;
              part_qty_next = left;
              nres_next     = k_inc;
              fill_f_next   = fill - k;
              state_next    = S_FREE;
            end else if (alu_res[QTY_WIDTH-1:0] == '0 || k_inc == fill) begin
              part_next   = 1'b0;
              nres_next   = k_inc;
              fill_f_next = fill - k_inc;
              state_next  = S_FREE;
            end else begin
              left_next     = alu_res[QTY_WIDTH-1:0];
              k_next        = k_inc;
              scan_ptr_next = next_slot(scan_ptr);
              state_next    = S_RD;
            end
          end
          default: begin
            alu_a        = total_f;
            alu_b        = mem_ramt;
            alu_sub      = 1'b1;
            total_f_next = alu_res[QTY_WIDTH-1:0];
            if (k_inc == req_cnt) begin
              part_next   = 1'b0;
              nres_next   = req_cnt;
              fill_f_next = fill - req_cnt;
              state_next  = S_FREE;
            end else begin
              k_next        = k_inc;
              scan_ptr_next = next_slot(scan_ptr);
              state_next    = S_RD;
            end
          end
        endcase
      end

      S_PUSHW: begin
        if (fill == FULL_CNT) begin
          st_next = ST_FULL;
        end else begin
          mem_we       = 1'b1;
          tail_next    = next_slot(tail);
          fill_next    = fill + ONE_CNT;
          total_next   = sum;
          fill_f_next  = fill + ONE_CNT;
          total_f_next = sum;
          st_next      = ST_OK;
        end
        state_next = S_FREE;
      end

      S_FREE: begin
        alu_a       = capacity;
        alu_b       = total_f;
        alu_sub     = 1'b1;
        free_r_next = unlimited ? '1 : alu_res;
        k_next      = '0;
        state_next  = single ? S_SOLO : S_ERD;
      end

      S_SOLO: begin
        if (out_free_slot) begin
          out_load   = 1'b1;
          ld_status  = st;
          state_next = S_IDLE;
        end
      end

      S_ERD: begin
        state_next = S_EEV;
      end

      // Second pass: emit one removed entry or part per transfer
      S_EEV: begin
        alu_a   = mem_ramt;
        alu_b   = part_qty;
        alu_sub = 1'b1;
        if (out_free_slot) begin
          out_load      = 1'b1;
          ld_item_valid = 1'b1;
          ld_id         = mem_rid;
          ld_qty        = (is_last && part) ? part_qty : mem_ramt;
          ld_last       = is_last;
          if (is_last && part) begin
            // remainder stays at the front under the same id
            mem_we    = 1'b1;
            mem_waddr = head;
            mem_wid   = mem_rid;
            mem_wamt  = alu_res[QTY_WIDTH-1:0];
          end else begin
            head_next = next_slot(head);
          end
          if (is_last) begin
            fill_next  = fill_f;
            total_next = total_f;
            state_next = S_IDLE;
          end else begin
            k_next     = k_inc;
            state_next = S_ERD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      total     <= '0;
      capacity  <= '0;
      unlimited <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
      total <= total_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAPACITY:  capacity  <= cfg_wdata;
          CFG_UNLIMITED: unlimited <= cfg_wdata[0];
          default:       capacity  <= capacity;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_func <= req_func_next;
    req_id   <= req_id_next;
    req_qty  <= req_qty_next;
    req_cnt  <= req_cnt_next;
    sum      <= sum_next;
    scan_ptr <= scan_ptr_next;
    k        <= k_next;
    left     <= left_next;
    part     <= part_next;
    part_qty <= part_qty_next;
    nres     <= nres_next;
    fill_f   <= fill_f_next;
    total_f  <= total_f_next;
    free_r   <= free_r_next;
    st       <= st_next;
    single   <= single_next;
    if (out_load) begin
      out_status     <= ld_status;
      out_item_valid <= ld_item_valid;
      out_id         <= ld_id;
      out_qty        <= ld_qty;
      out_last       <= ld_last;
      out_count      <= fill_f;
      out_total      <= total_f;
      out_free       <= free_r;
    end
  end

endmodule
